// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the top-level RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PAT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// pat_pkg
// Payload types and fixed constants for the proximity averaging block.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SPREAD_W = 11;
  localparam int LIMIT_W  = 12;
  localparam int MARGIN_W = 10;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Word select bit of paddr; 0 = detect_margin
  localparam logic REG_DETECT_MARGIN = 1'b0;

  typedef enum logic {
    KIND_MEASURE = 1'b0,
    KIND_CALIB   = 1'b1
  } kind_e;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
  } pat_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                raised;
    logic [SAMPLE_W-1:0] ambient_level;
    logic [SPREAD_W-1:0] ambient_spread;
    logic                calibrated;
  } pat_out_t;

endpackage

// ===== rtl/pat_ram.sv =====
// ----------------------------------------------------------------------------
// pat_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module pat_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pat_div.sv =====
// ----------------------------------------------------------------------------
// pat_div
// Shared divide-by-constant unit: multiplies by a rounded-up reciprocal.
// ----------------------------------------------------------------------------
module pat_div #(
  parameter int DW = 14,
  parameter int RS = 18
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [RS:0]   recip_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int PW = DW + RS + 1;

  logic          busy_q, done_q;
  logic [DW-1:0] dvd_q, quo_q;
  logic [RS:0]   rcp_q;
  logic [PW-1:0] prod;

  // Operands registered on start, product taken the next cycle
  assign prod = PW'(dvd_q) * PW'(rcp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rcp_q <= recip_i;
    end
    if (busy_q) begin
      quo_q <= prod[RS +: DW];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/proximity_average_threshold_top.sv =====
// ----------------------------------------------------------------------------
// proximity_average_threshold_top
// Ring average of measurement samples against a calibrated ambient threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one request: kind and a
//   10-bit sample. Kind 0 writes the measurement ring, kind 1 collects a
//   calibration sample. Every request gives exactly one result on
//   out_valid_o / out_stall_i: ring average, ambient, spread, raised flag and
//   a calibrated flag for the request that closed a run.
//   One request is worked at a time; in_stall_o is high from accept until its
//   result is loaded into the output register. All divisions are by the ring
//   or run depth and go through one shared reciprocal multiplier. A
//   measurement updates the ring before the average is divided; a request
//   that closes a run first divides for the new ambient and walks the store
//   once for the absolute deviation, then divides for the spread. The input
//   is free again in the same cycle as the result goes valid.
//   The output register lets the next request be accepted while a result is
//   still held; a stalled result only holds the sequencer at its last step.
//   Reset clears the ring (valid bits), counters, sums, ambient, spread and
//   margin. No clearing pass is needed. detect_margin is written over APB.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module proximity_average_threshold_top #(
  parameter int RING_DEPTH    = 8,
  parameter int CALIB_SAMPLES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pat_pkg::pat_in_t                  in_req_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pat_pkg::pat_out_t                 out_rsp_o,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pat_pkg::APB_AW-1:0]        paddr,
  input  logic [pat_pkg::APB_DW-1:0]        pwdata,
  output logic [pat_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  import pat_pkg::*;

  // Widths derived from the depths
  localparam int RPW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RSW = SAMPLE_W + $clog2(RING_DEPTH);
  localparam int CAW = (CALIB_SAMPLES > 1) ? $clog2(CALIB_SAMPLES) : 1;
  localparam int CCW = $clog2(CALIB_SAMPLES + 1);
  localparam int CSW = SAMPLE_W + $clog2(CALIB_SAMPLES);
  localparam int DW  = (RSW > CSW) ? RSW : CSW;
  localparam int MAXD = (RING_DEPTH > CALIB_SAMPLES) ? RING_DEPTH : CALIB_SAMPLES;
  localparam int CLW = $clog2(MAXD);
  localparam int RS  = DW + CLW;
  localparam int RCW = RS + 1;
  localparam logic [RSW-1:0] RING_SUM_MAX = RSW'(RING_DEPTH * ((1 << SAMPLE_W) - 1));
  localparam logic [CCW-1:0] RUN_LEN = CCW'(CALIB_SAMPLES);

  // Reciprocals rounded up; the rounding error stays below 2**CLW, so the
  // quotient is exact for every dividend below 2**DW.
  localparam logic [RS:0] RING_RECIP =
    RCW'(((64'd1 << RS) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));
  localparam logic [RS:0] CALIB_RECIP =
    RCW'(((64'd1 << RS) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

  // Sequencer
  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_RING     = 10'b00_0000_0010,
    ST_LVL_GO   = 10'b00_0000_0100,
    ST_LVL_WAIT = 10'b00_0000_1000,
    ST_SWEEP    = 10'b00_0001_0000,
    ST_DEV_GO   = 10'b00_0010_0000,
    ST_DEV_WAIT = 10'b00_0100_0000,
    ST_AVG_GO   = 10'b00_1000_0000,
    ST_AVG_WAIT = 10'b01_0000_0000,
    ST_RESULT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Control state
  logic [RPW-1:0]        ring_pos_q;
  logic [RING_DEPTH-1:0] ring_vld_q;
  logic [RSW-1:0]        ring_sum_q;
  logic [CCW-1:0]        calib_count_q;
  logic [CSW-1:0]        calib_sum_q;
  logic [SAMPLE_W-1:0]   ambient_q;
  logic [SPREAD_W-1:0]   spread_q;
  logic [MARGIN_W-1:0]   margin_q;
  logic [CCW-1:0]        sweep_idx_q;
  logic                  sweep_pend_q;
  logic [CSW-1:0]        dev_sum_q;
  logic                  out_valid_q;

  // Payload registers
  logic [SAMPLE_W-1:0]   sample_q;
  logic                  calib_done_q;
  logic [SAMPLE_W-1:0]   avg_q;
  pat_out_t              out_q;

  logic in_acc, out_free, cfg_wr;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // -------------------------------------------------------------- APB
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DETECT_MARGIN) begin
      prdata = APB_DW'(margin_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= '0;
    end else if (cfg_wr && (paddr[2] == REG_DETECT_MARGIN)) begin
      margin_q <= pwdata[MARGIN_W-1:0];
    end
  end

  // -------------------------------------------------------------- memories
  logic [SAMPLE_W-1:0] ring_rdata, calib_rdata;
  logic                ring_we, calib_we;

  // Ring read address follows the write slot, so the old sample is ready
  // in the cycle after accept.
  pat_ram #(.WIDTH(SAMPLE_W), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_pos_q),
    .wdata_i (sample_q),
    .raddr_i (ring_pos_q),
    .rdata_o (ring_rdata)
  );

  pat_ram #(.WIDTH(SAMPLE_W), .DEPTH(CALIB_SAMPLES)) u_calib_ram (
    .clk_i   (clk_i),
    .we_i    (calib_we),
    .waddr_i (calib_count_q[CAW-1:0]),
    .wdata_i (in_req_i.sample),
    .raddr_i (sweep_idx_q[CAW-1:0]),
    .rdata_o (calib_rdata)
  );

  assign ring_we  = (state_q == ST_RING);
  assign calib_we = in_acc && (in_req_i.kind == KIND_CALIB);

  // -------------------------------------------------------------- divider
  logic          div_start, div_busy, div_done;
  logic [DW-1:0] div_dividend, div_quo;
  logic [RS:0]   div_recip;

  pat_div #(.DW(DW), .RS(RS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .recip_i    (div_recip),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DW'(ring_sum_q);
    div_recip    = RING_RECIP;
    case (state_q)
      ST_LVL_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(calib_sum_q);
        div_recip    = CALIB_RECIP;
      end
      ST_DEV_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(dev_sum_q);
        div_recip    = CALIB_RECIP;
      end
      ST_AVG_GO: begin
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------- datapath
  logic [SAMPLE_W-1:0] ring_old, abs_diff;
  logic [CCW-1:0]      count_inc;
  logic                run_full, sweep_end;
  logic [LIMIT_W-1:0]  limit;

  // Unwritten ring slots read as zero
  assign ring_old  = ring_vld_q[ring_pos_q] ? ring_rdata : '0;
  assign count_inc = calib_count_q + CCW'(1);
  assign run_full  = (count_inc == RUN_LEN);
  assign sweep_end = (sweep_idx_q == RUN_LEN);
  assign abs_diff  = (calib_rdata >= ambient_q) ? (calib_rdata - ambient_q)
                                                : (ambient_q - calib_rdata);
  assign limit     = LIMIT_W'(ambient_q) + LIMIT_W'(spread_q) + LIMIT_W'(margin_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_i.kind == KIND_MEASURE) begin
            state_d = ST_RING;
          end else if (run_full) begin
            state_d = ST_LVL_GO;
          end else begin
            state_d = ST_AVG_GO;
          end
        end
      end
      ST_RING:     state_d = ST_AVG_GO;
      ST_LVL_GO:   state_d = ST_LVL_WAIT;
      ST_LVL_WAIT: if (div_done) state_d = ST_SWEEP;
      ST_SWEEP:    if (sweep_end && !sweep_pend_q) state_d = ST_DEV_GO;
      ST_DEV_GO:   state_d = ST_DEV_WAIT;
      ST_DEV_WAIT: if (div_done) state_d = ST_AVG_GO;
      ST_AVG_GO:   state_d = ST_AVG_WAIT;
      ST_AVG_WAIT: if (div_done) state_d = ST_RESULT;
      ST_RESULT:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ring_pos_q    <= '0;
      ring_vld_q    <= '0;
      ring_sum_q    <= '0;
      calib_count_q <= '0;
      calib_sum_q   <= '0;
      ambient_q     <= '0;
      spread_q      <= '0;
      sweep_idx_q   <= '0;
      sweep_pend_q  <= 1'b0;
      dev_sum_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      // Load wins over drain: a new result replaces the one leaving
      if ((state_q == ST_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (calib_we) begin
            calib_count_q <= count_inc;
            calib_sum_q   <= calib_sum_q + CSW'(in_req_i.sample);
          end
        end
        ST_RING: begin
          ring_sum_q             <= ring_sum_q - RSW'(ring_old) + RSW'(sample_q);
          ring_vld_q[ring_pos_q] <= 1'b1;
          if (ring_pos_q == RPW'(RING_DEPTH - 1)) begin
            ring_pos_q <= '0;
          end else begin
            ring_pos_q <= ring_pos_q + RPW'(1);
          end
        end
        ST_LVL_WAIT: begin
          if (div_done) begin
            // New ambient; run restarts
            ambient_q     <= div_quo[SAMPLE_W-1:0];
            calib_count_q <= '0;
            calib_sum_q   <= '0;
            sweep_idx_q   <= '0;
            sweep_pend_q  <= 1'b0;
            dev_sum_q     <= '0;
          end
        end
        ST_SWEEP: begin
          // Address issued, its data summed in the cycle after
          sweep_pend_q <= !sweep_end;
          if (!sweep_end) begin
            sweep_idx_q <= sweep_idx_q + CCW'(1);
          end
          if (sweep_pend_q) begin
            dev_sum_q <= dev_sum_q + CSW'(abs_diff);
          end
        end
        ST_DEV_WAIT: begin
          if (div_done) begin
            spread_q <= {div_quo[SAMPLE_W-1:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q     <= in_req_i.sample;
      calib_done_q <= (in_req_i.kind == KIND_CALIB) && run_full;
    end
    if ((state_q == ST_AVG_WAIT) && div_done) begin
      avg_q <= div_quo[SAMPLE_W-1:0];
    end
    if ((state_q == ST_RESULT) && out_free) begin
      out_q.average        <= avg_q;
      out_q.raised         <= (LIMIT_W'(avg_q) > limit);
      out_q.ambient_level  <= ambient_q;
      out_q.ambient_spread <= spread_q;
      out_q.calibrated     <= calib_done_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // -------------------------------------------------------------- checks
  `PAT_ASSERT_IMPL(a_div_start_idle, clk_i, rst_ni, div_start, !div_busy, "divider restarted")
  `PAT_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_acc, in_stall_o, "accept ignored")
  `PAT_ASSERT_IMPL(a_ring_sum_bound, clk_i, rst_ni, 1'b1, ring_sum_q <= RING_SUM_MAX, "ring sum")
  `PAT_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, !in_stall_o, calib_count_q < RUN_LEN, "run count")

endmodule

// ===== tb/proximity_checker.sv =====
// ----------------------------------------------------------------------------
// proximity_checker
// Predicts and checks every result of the proximity averaging block.
// Watches the request, result and register channels, keeps its own copy of
// the ring, calibration run and margin, and compares each result in order.
// ----------------------------------------------------------------------------
module proximity_checker
  import pat_pkg::*;
#(
  parameter int RING_DEPTH    = 8,
  parameter int CALIB_SAMPLES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  pat_in_t           in_req_i,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  pat_out_t          out_rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                fails_o,
  output int                waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_AW-1:0] MARGIN_ADDR = {REG_DETECT_MARGIN, 2'b00};
  localparam int                REPORT_MAX  = 10;

  logic [SAMPLE_W-1:0] ring_q [RING_DEPTH];
  int unsigned         ring_slot;
  logic [SAMPLE_W-1:0] calib_q [CALIB_SAMPLES];
  int unsigned         calib_seen;
  int unsigned         calib_total;
  logic [SAMPLE_W-1:0] ambient_q;
  logic [SPREAD_W-1:0] spread_q;
  logic [MARGIN_W-1:0] margin_q;

  pat_out_t expected_results [$];
  pat_out_t oldest;
  int       mismatches;
  int       checked;

  // advance the predicted state by one request and return its result
  function automatic pat_out_t predict_result(pat_in_t req);
    pat_out_t    rsp;
    int unsigned ring_sum;
    int unsigned level;
    int unsigned dev;
    int unsigned limit;
    int          i;
    rsp = '0;
    if (kind_e'(req.kind) == KIND_MEASURE) begin
      ring_q[ring_slot] = req.sample;
      ring_slot = (ring_slot + 1) % RING_DEPTH;
    end else begin
      calib_q[calib_seen] = req.sample;
      calib_total += req.sample;
      calib_seen++;
      if (calib_seen == CALIB_SAMPLES) begin
        level = calib_total / CALIB_SAMPLES;
        dev = 0;
        for (i = 0; i < CALIB_SAMPLES; i++) begin
          if (calib_q[i] >= level) dev += calib_q[i] - level;
          else dev += level - calib_q[i];
        end
        ambient_q   = level[SAMPLE_W-1:0];
        spread_q    = SPREAD_W'((dev / CALIB_SAMPLES) * 2);
        calib_seen  = 0;
        calib_total = 0;
        rsp.calibrated = 1'b1;
      end
    end
    ring_sum = 0;
    for (i = 0; i < RING_DEPTH; i++) ring_sum += ring_q[i];
    rsp.average        = SAMPLE_W'(ring_sum / RING_DEPTH);
    limit              = ambient_q + spread_q + margin_q;
    rsp.raised         = (rsp.average > limit);
    rsp.ambient_level  = ambient_q;
    rsp.ambient_spread = spread_q;
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RING_DEPTH; i++) ring_q[i] = '0;
      ring_slot   = 0;
      calib_seen  = 0;
      calib_total = 0;
      ambient_q   = '0;
      spread_q    = '0;
      margin_q    = '0;
      mismatches  = 0;
      checked     = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == MARGIN_ADDR) begin
        margin_q = pwdata[MARGIN_W-1:0];
      end
      // results first: a result never belongs to a request taken at the same edge
      if (out_valid_o && !out_stall_i) begin
        checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: unexpected result avg=%0d raised=%0b amb=%0d spr=%0d cal=%0b",
                     $realtime, out_rsp_o.average, out_rsp_o.raised,
                     out_rsp_o.ambient_level, out_rsp_o.ambient_spread,
                     out_rsp_o.calibrated);
          end
        end else begin
          oldest = expected_results.pop_front();
          if (out_rsp_o.average        !== oldest.average       ||
              out_rsp_o.raised         !== oldest.raised        ||
              out_rsp_o.ambient_level  !== oldest.ambient_level ||
              out_rsp_o.ambient_spread !== oldest.ambient_spread ||
              out_rsp_o.calibrated     !== oldest.calibrated) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: result %0d exp avg=%0d raised=%0b amb=%0d spr=%0d cal=%0b",
                       $realtime, checked, oldest.average, oldest.raised,
                       oldest.ambient_level, oldest.ambient_spread, oldest.calibrated);
              $display("%0t: result %0d got avg=%0d raised=%0b amb=%0d spr=%0d cal=%0b",
                       $realtime, checked, out_rsp_o.average, out_rsp_o.raised,
                       out_rsp_o.ambient_level, out_rsp_o.ambient_spread,
                       out_rsp_o.calibrated);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_result(in_req_i));
      end
    end
    waiting_o <= expected_results.size();
    fails_o   <= mismatches;
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the proximity averaging block.
// Drives a short directed sequence and then random measurement and
// calibration requests over several margin settings, with random idling on
// both channels; the checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pat_pkg::*;

  localparam int RING_DEPTH    = 8;
  localparam int CALIB_SAMPLES = 16;

  localparam logic [APB_AW-1:0] MARGIN_ADDR = {REG_DETECT_MARGIN, 2'b00};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  localparam int PHASES         = 10;
  localparam int PHASE_REQUESTS = 188;
  localparam int HOLD_PHASE     = 2;    // phase with the long result hold-off
  localparam int QUIET_PHASE    = 1;    // phase run without any idling
  localparam int LONG_HOLD      = 250;  // cycles the result side holds off
  localparam int SETTLE_CYCLES  = 20;
  localparam int DRAIN_CYCLES   = 200;
  // worst quiet stretch: long hold-off plus a closing request plus a long gap
  localparam int WATCHDOG_LIMIT = 3000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  pat_in_t           in_req_i;
  logic              out_valid_o;
  logic              out_stall_i;
  pat_out_t          out_rsp_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fails;
  int waiting;

  // shared between the stimulus and the result-side process
  bit idling_on;
  int hold_asked;
  int hold_served;

  proximity_average_threshold_top #(
    .RING_DEPTH   (RING_DEPTH),
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  proximity_checker #(
    .RING_DEPTH   (RING_DEPTH),
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) result_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fails_o    (fails),
    .waiting_o  (waiting)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Gap lengths: mostly a few cycles, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random request around a working level. Calibration samples stay close to
  // it; measurements lean upwards so that the flag goes both ways. A few are
  // pinned to the rails or drawn over the full range.
  function automatic pat_in_t draw_request(int centre, int reach);
    pat_in_t req;
    int      pick;
    int      val;
    req.kind = ($urandom_range(0, 99) < 55) ? KIND_MEASURE : KIND_CALIB;
    pick = $urandom_range(0, 15);
    if (pick == 0) val = 0;
    else if (pick == 1) val = int'(SAMPLE_MAX);
    else if (pick == 2) val = $urandom_range(0, SAMPLE_MAX);
    else if (req.kind == KIND_CALIB) val = centre + int'($urandom_range(0, 2 * reach)) - reach;
    else val = centre + int'($urandom_range(0, 4 * reach + 64)) - reach;
    if (val < 0) val = 0;
    if (val > SAMPLE_MAX) val = int'(SAMPLE_MAX);
    req.sample = val[SAMPLE_W-1:0];
    return req;
  endfunction

  function automatic pat_in_t make_request(kind_e kind, logic [SAMPLE_W-1:0] sample);
    pat_in_t req;
    req.kind   = kind;
    req.sample = sample;
    return req;
  endfunction

  // Offer one request and hold it until taken. Valid stays high into the
  // next request unless a gap is drawn, so it is never dropped and raised
  // in the same step.
  task automatic offer(input pat_in_t req);
    int gap;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait for every outstanding result. The first edge lets
  // the checker's count catch up with the last request taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup then access cycle; junk in the upper data bits must be ignored.
  task automatic write_margin(input logic [MARGIN_W-1:0] margin);
    logic [APB_DW-1:0] junk;
    junk = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MARGIN_ADDR;
    pwdata  <= {junk[APB_DW-1:MARGIN_W], margin};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Margin per phase: both rails, one step above zero, otherwise mostly small
  // so that the flag still fires.
  function automatic logic [MARGIN_W-1:0] margin_for(int phase);
    if (phase == 0) return '1;
    if (phase == 1) return '0;
    if (phase == PHASES - 1) return MARGIN_W'(1);
    if ($urandom_range(0, 3) == 0) return MARGIN_W'($urandom_range(0, 1023));
    return MARGIN_W'($urandom_range(0, 40));
  endfunction

  // Result side: random stalls while idling is on, plus the long hold-off
  // when the stimulus asks for one. The hold-off is counted here, so the
  // sender keeps offering and the block backs up into its input.
  initial begin : result_sink
    int n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_served) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_served++;
        out_stall_i <= 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        n = pick_gap();
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Anything taken on either channel or the register port counts as progress.
  wire progress = (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                  (psel && penable && pready);

  initial begin : watchdog
    int stale;
    stale = 0;
    while (stale < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (progress) stale = 0;
      else stale++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int centre;
    int reach;
    int phase;
    int n;
    idling_on   = 1'b1;
    hold_asked  = 0;
    hold_served = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed, margin at its reset value. A zero sample into the empty ring
    // gives an average equal to the limit, so the flag must stay low.
    offer(make_request(KIND_MEASURE, '0));
    // fill the ring at full scale, then wrap it with one zero
    for (n = 0; n < RING_DEPTH; n++) offer(make_request(KIND_MEASURE, SAMPLE_MAX));
    offer(make_request(KIND_MEASURE, '0));
    // a whole calibration run swinging rail to rail: widest spread, and the
    // closing request already carries the new ambient and spread
    for (n = 0; n < CALIB_SAMPLES; n++) begin
      offer(make_request(KIND_CALIB, n[0] ? SAMPLE_MAX : '0));
    end

    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      write_margin(margin_for(phase));
      idling_on = (phase != QUIET_PHASE);
      if (phase == HOLD_PHASE) hold_asked++;
      centre = $urandom_range(0, 1023);
      reach  = $urandom_range(0, 96);
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        // move the working level now and then
        if ($urandom_range(0, 47) == 0) begin
          centre = $urandom_range(0, 1023);
          reach  = $urandom_range(0, 96);
        end
        offer(draw_request(centre, reach));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0 && waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pat_pkg.sv
rtl/pat_ram.sv
rtl/pat_div.sv
rtl/proximity_average_threshold_top.sv
tb/proximity_checker.sv
tb/tb.sv
